>>> src/cmpf_pkg.sv
// Shared constants and item types for the color matrix pixel filter.
// No dependencies; every other file imports this package.
package cmpf_pkg;

	// Field and format widths
	localparam int PIX_W            = 32;
	localparam int CHAN_W           = 8;
	localparam int CHAN_FRAC_BITS   = 8;
	localparam int OFFSET_WIDTH     = 16;
	localparam int OFFSET_FRAC_BITS = 4;
	localparam int NUM_ROWS         = 4;
	localparam int NUM_COLORS       = 3;

	// Defaults for the gain format
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int GAIN_WIDTH_DEF     = 12;

	// Unpremultiply divider: dividend is c*255 with 8 fraction bits
	localparam int DIV_BITS   = 2 * CHAN_W + CHAN_FRAC_BITS;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

	// Pipeline depth, input accept edge to result strobe
	localparam int MATRIX_STAGES = 3;
	localparam int PREMUL_STAGES = 2;
	localparam int LATENCY       = DIV_STAGES + MATRIX_STAGES + PREMUL_STAGES;

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_RED_GAINS    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAINS  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAINS   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_GAINS  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFFSET  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_OFFSET = CFG_IDX_W'(7);

	typedef logic [CHAN_W-1:0]   chan_t;
	typedef logic [DIV_BITS-1:0] straight_t;

	// Straight (unpremultiplied) item, divider to matrix
	typedef struct packed {
		logic      valid;
		chan_t     alpha;
		straight_t red;
		straight_t green;
		straight_t blue;
	} straight_pix_t;

	// Clamped matrix result, matrix to premultiply
	typedef struct packed {
		logic  valid;
		chan_t alpha;
		chan_t red;
		chan_t green;
		chan_t blue;
	} clamped_pix_t;

endpackage

>>> src/cmpf_unpremul.sv
// Unpremultiply pipeline: c*255*256/a per color, restoring division,
// DIV_STEP quotient bits per stage. Depends on cmpf_pkg.
module cmpf_unpremul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	input  logic [cmpf_pkg::PIX_W-1:0]   pixel,
	output cmpf_pkg::straight_pix_t      straight
);
	import cmpf_pkg::*;

	typedef struct packed {
		chan_t     rem;
		straight_t num;
		straight_t quo;
	} div_lane_t;

	// Scale a color to c*255 with CHAN_FRAC_BITS fraction bits
	function automatic straight_t scaled(chan_t c);
		logic [2*CHAN_W-1:0] c255;
		c255 = {c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c};
		return {c255, {CHAN_FRAC_BITS{1'b0}}};
	endfunction

	// Retire DIV_STEP quotient bits
	function automatic div_lane_t div_step(div_lane_t x, chan_t d);
		div_lane_t       y;
		logic [CHAN_W:0] t;
		logic            qbit;
		y = x;
		for (int i = 0; i < DIV_STEP; i++) begin
			t     = {y.rem, y.num[DIV_BITS-1]};
			y.num = {y.num[DIV_BITS-2:0], 1'b0};
			qbit  = (t >= {1'b0, d});
			if (qbit) begin
				t = t - {1'b0, d};
			end
			y.rem = t[CHAN_W-1:0];
			y.quo = {y.quo[DIV_BITS-2:0], qbit};
		end
		return y;
	endfunction

	logic      valid_s [DIV_STAGES];
	chan_t     alpha_s [DIV_STAGES];
	div_lane_t lane_s  [DIV_STAGES][NUM_COLORS];
	div_lane_t lane_d  [DIV_STAGES][NUM_COLORS];

	// Stage 0 steps the input pixel; later ones step the prior stage
	always_comb begin
		for (int st = 0; st < DIV_STAGES; st++) begin
			for (int l = 0; l < NUM_COLORS; l++) begin
				if (st == 0) begin
					lane_d[st][l] = div_step('{rem: '0,
						num: scaled(pixel[(NUM_COLORS-1-l)*CHAN_W +: CHAN_W]),
						quo: '0}, pixel[PIX_W-1 -: CHAN_W]);
				end else begin
					lane_d[st][l] = div_step(lane_s[st-1][l], alpha_s[st-1]);
				end
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int st = 0; st < DIV_STAGES; st++) begin
				valid_s[st] <= 1'b0;
			end
		end else begin
			valid_s[0] <= valid;
			for (int st = 1; st < DIV_STAGES; st++) begin
				valid_s[st] <= valid_s[st-1];
			end
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		alpha_s[0] <= pixel[PIX_W-1 -: CHAN_W];
		for (int st = 1; st < DIV_STAGES; st++) begin
			alpha_s[st] <= alpha_s[st-1];
		end
		for (int st = 0; st < DIV_STAGES; st++) begin
			for (int l = 0; l < NUM_COLORS; l++) begin
				lane_s[st][l] <= lane_d[st][l];
			end
		end
	end

	// Zero alpha gives straight colors of zero
	always_comb begin
		straight.valid = valid_s[DIV_STAGES-1];
		straight.alpha = alpha_s[DIV_STAGES-1];
		if (alpha_s[DIV_STAGES-1] != '0) begin
			straight.red   = lane_s[DIV_STAGES-1][0].quo;
			straight.green = lane_s[DIV_STAGES-1][1].quo;
			straight.blue  = lane_s[DIV_STAGES-1][2].quo;
		end else begin
			straight.red   = '0;
			straight.green = '0;
			straight.blue  = '0;
		end
	end

endmodule

>>> src/cmpf_matrix.sv
// 4x5 color matrix: products, partial sums with offset, sum and clamp.
// Three register stages. Depends on cmpf_pkg.
module cmpf_matrix #(
	parameter int GAIN_FRAC_BITS = cmpf_pkg::GAIN_FRAC_BITS_DEF,
	parameter int GAIN_WIDTH     = cmpf_pkg::GAIN_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  cmpf_pkg::straight_pix_t                straight,
	input  logic [4*GAIN_WIDTH-1:0]                row_gains  [cmpf_pkg::NUM_ROWS],
	input  logic signed [cmpf_pkg::OFFSET_WIDTH-1:0] row_offset [cmpf_pkg::NUM_ROWS],
	output cmpf_pkg::clamped_pix_t                 clamped
);
	import cmpf_pkg::*;

	localparam int FB      = GAIN_FRAC_BITS + CHAN_FRAC_BITS;
	localparam int PW      = GAIN_WIDTH + DIV_BITS + 1;
	localparam int OW      = OFFSET_WIDTH + FB - OFFSET_FRAC_BITS;
	localparam int SW      = ((PW > OW) ? PW : OW) + 2;
	localparam int HW      = SW - FB;
	localparam int NUM_COL = 4;

	straight_t ch [NUM_COL];

	logic                 valid_s1;
	logic signed [PW-1:0] prod_s1 [NUM_ROWS][NUM_COL];
	logic                 valid_s2;
	logic signed [PW:0]   pair0_s2 [NUM_ROWS];
	logic signed [PW:0]   pair1_s2 [NUM_ROWS];
	logic signed [SW-1:0] off_s2   [NUM_ROWS];
	logic                 valid_s3;
	chan_t                chan_s3  [NUM_ROWS];

	logic signed [SW-1:0] total    [NUM_ROWS];
	logic [HW-1:0]        whole    [NUM_ROWS];
	chan_t                clip     [NUM_ROWS];

	// Alpha enters the matrix with the same fraction bits as the colors
	always_comb begin
		ch[0] = straight.red;
		ch[1] = straight.green;
		ch[2] = straight.blue;
		ch[3] = DIV_BITS'({straight.alpha, {CHAN_FRAC_BITS{1'b0}}});
	end

	// Sum, drop fraction, clamp to 0..255
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			total[r] = SW'(pair0_s2[r]) + SW'(pair1_s2[r]) + off_s2[r];
			whole[r] = total[r][SW-1:FB];
			if (total[r][SW-1]) begin
				clip[r] = '0;
			end else if (whole[r] > HW'(255)) begin
				clip[r] = '1;
			end else begin
				clip[r] = whole[r][CHAN_W-1:0];
			end
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= straight.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Multiply, pair up with offset, clamp
	always_ff @(posedge clk) begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int c = 0; c < NUM_COL; c++) begin
				prod_s1[r][c] <= $signed(row_gains[r][c*GAIN_WIDTH +: GAIN_WIDTH])
					* $signed({1'b0, ch[c]});
			end
			pair0_s2[r] <= (PW+1)'(prod_s1[r][0]) + (PW+1)'(prod_s1[r][1]);
			pair1_s2[r] <= (PW+1)'(prod_s1[r][2]) + (PW+1)'(prod_s1[r][3]);
			off_s2[r]   <= SW'(row_offset[r]) <<< (FB - OFFSET_FRAC_BITS);
			chan_s3[r]  <= clip[r];
		end
	end

	assign clamped.valid = valid_s3;
	assign clamped.red   = chan_s3[0];
	assign clamped.green = chan_s3[1];
	assign clamped.blue  = chan_s3[2];
	assign clamped.alpha = chan_s3[3];

endmodule

>>> src/cmpf_premul.sv
// Re-premultiply: c*a then truncating divide by 255, packed into ARGB32.
// Two register stages; the second drives the result ports. Depends on cmpf_pkg.
module cmpf_premul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmpf_pkg::clamped_pix_t     clamped,
	output logic                       done,
	output logic [cmpf_pkg::PIX_W-1:0] pixel
);
	import cmpf_pkg::*;

	localparam int XW = 2 * CHAN_W;

	logic          valid_s1;
	logic [XW-1:0] prod_s1 [NUM_COLORS];
	chan_t         alpha_s1;
	logic          valid_s2;
	logic [PIX_W-1:0] pixel_s2;

	chan_t    color [NUM_COLORS];
	logic [XW:0] adj [NUM_COLORS];
	chan_t    quot [NUM_COLORS];

	assign color[0] = clamped.red;
	assign color[1] = clamped.green;
	assign color[2] = clamped.blue;

	// floor(x/255) = (x + 1 + (x >> 8)) >> 8 over the 16-bit product range
	always_comb begin
		for (int l = 0; l < NUM_COLORS; l++) begin
			adj[l]  = {1'b0, prod_s1[l]} + (XW+1)'(1)
				+ (XW+1)'(prod_s1[l] >> CHAN_W);
			quot[l] = adj[l][XW-1:CHAN_W];
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= clamped.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply by new alpha, then divide and pack
	always_ff @(posedge clk) begin
		for (int l = 0; l < NUM_COLORS; l++) begin
			prod_s1[l] <= XW'(color[l]) * XW'(clamped.alpha);
		end
		alpha_s1 <= clamped.alpha;
		pixel_s2 <= {alpha_s1, quot[0], quot[1], quot[2]};
	end

	assign done  = valid_s2;
	assign pixel = pixel_s2;

endmodule

>>> src/color_matrix_pixel_filter.sv
// Top level of the color matrix pixel filter: configuration registers and
// the unpremultiply, matrix and premultiply pipelines. Depends on cmpf_pkg.
//
//   channel   handshake                  payload
//   input     start, busy                pixel_in[31:0]
//   result    done (one-cycle strobe)    pixel_out[31:0]
//   config    cfg_valid, cfg_ready       cfg_index[3:0], cfg_data[4*GAIN_WIDTH-1:0]
//
// One pixel enters per clock; busy stays low. Each result passes through 12
// divider stages (2 quotient bits each for c*255*256/a), 3 matrix stages and
// 2 premultiply stages. Reset clears all valid bits and loads identity gains
// and zero offsets. The receiver cannot stall; every stage advances each cycle.
module color_matrix_pixel_filter #(
	parameter int GAIN_FRAC_BITS = cmpf_pkg::GAIN_FRAC_BITS_DEF,
	parameter int GAIN_WIDTH     = cmpf_pkg::GAIN_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [cmpf_pkg::PIX_W-1:0]       pixel_in,
	output logic                             done,
	output logic [cmpf_pkg::PIX_W-1:0]       pixel_out,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cmpf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [4*GAIN_WIDTH-1:0]          cfg_data
);
	import cmpf_pkg::*;

	localparam int RW = 4 * GAIN_WIDTH;

	logic [RW-1:0]                  gains_q  [NUM_ROWS];
	logic signed [OFFSET_WIDTH-1:0] offset_q [NUM_ROWS];

	straight_pix_t straight;
	clamped_pix_t  clamped;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				gains_q[r]  <= RW'(1) << (r * GAIN_WIDTH + GAIN_FRAC_BITS);
				offset_q[r] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RED_GAINS:    gains_q[0]  <= cfg_data;
				REG_GREEN_GAINS:  gains_q[1]  <= cfg_data;
				REG_BLUE_GAINS:   gains_q[2]  <= cfg_data;
				REG_ALPHA_GAINS:  gains_q[3]  <= cfg_data;
				REG_RED_OFFSET:   offset_q[0] <= cfg_data[OFFSET_WIDTH-1:0];
				REG_GREEN_OFFSET: offset_q[1] <= cfg_data[OFFSET_WIDTH-1:0];
				REG_BLUE_OFFSET:  offset_q[2] <= cfg_data[OFFSET_WIDTH-1:0];
				REG_ALPHA_OFFSET: offset_q[3] <= cfg_data[OFFSET_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	cmpf_unpremul u_unpremul (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (start && !busy),
		.pixel    (pixel_in),
		.straight (straight)
	);

	cmpf_matrix #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.GAIN_WIDTH     (GAIN_WIDTH)
	) u_matrix (
		.clk        (clk),
		.arst_n     (arst_n),
		.straight   (straight),
		.row_gains  (gains_q),
		.row_offset (offset_q),
		.clamped    (clamped)
	);

	cmpf_premul u_premul (
		.clk     (clk),
		.arst_n  (arst_n),
		.clamped (clamped),
		.done    (done),
		.pixel   (pixel_out)
	);

	// A premultiplied color never exceeds its alpha
	a_color_le_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pixel_out[23:16] <= pixel_out[31:24])
			&& (pixel_out[15:8] <= pixel_out[31:24])
			&& (pixel_out[7:0] <= pixel_out[31:24]))
		else $error("premultiplied color above alpha");

	// Every result traces back to an item accepted earlier
	a_done_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted item");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for color_matrix_pixel_filter: directed and random pixels,
// register writes between phases, every result compared against an in-line predictor.
// Depends on cmpf_pkg and the color_matrix_pixel_filter RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import cmpf_pkg::*;

	localparam int GFB         = GAIN_FRAC_BITS_DEF;
	localparam int GW          = GAIN_WIDTH_DEF;
	localparam int GAIN_BUS_W  = NUM_ROWS * GW;
	localparam int SUM_FRAC    = GFB + CHAN_FRAC_BITS;
	localparam int NUM_REGS    = 2 * NUM_ROWS;
	localparam int STALL_LIMIT = 1000;

	localparam logic [GW-1:0] GAIN_ONE = GW'(1 << GFB);
	localparam logic [GW-1:0] GAIN_MAX = {1'b0, {(GW-1){1'b1}}};
	localparam logic [GW-1:0] GAIN_MIN = {1'b1, {(GW-1){1'b0}}};
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MIN = {1'b1, {(OFFSET_WIDTH-1){1'b0}}};

	typedef logic [NUM_ROWS-1:0][GAIN_BUS_W-1:0]   gain_set_t;
	typedef logic [NUM_ROWS-1:0][OFFSET_WIDTH-1:0] offset_set_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic [PIX_W-1:0]      pixel_in  = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [GAIN_BUS_W-1:0] cfg_data  = '0;
	logic                  busy;
	logic                  done;
	logic [PIX_W-1:0]      pixel_out;
	logic                  cfg_ready;

	// Register contents as the block should hold them
	gain_set_t   gains_now;
	offset_set_t offsets_now;

	logic [PIX_W-1:0] expected_pixels[$];
	int error_count     = 0;
	int pixels_sent     = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int stall_cycles    = 0;

	color_matrix_pixel_filter #(
		.GAIN_FRAC_BITS(GFB),
		.GAIN_WIDTH    (GW)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pixel_in (pixel_in),
		.done     (done),
		.pixel_out(pixel_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [GAIN_BUS_W-1:0] identity_row(int r);
		return GAIN_BUS_W'(GAIN_ONE) << (r * GW);
	endfunction

	// Unpremultiply, apply the matrix, clamp, premultiply again
	function automatic logic [PIX_W-1:0] filter_pixel(logic [PIX_W-1:0] p);
		longint straight[NUM_ROWS];
		longint alpha_in;
		longint sum;
		longint gain;
		longint offs;
		int     clamped[NUM_ROWS];
		int     new_alpha;
		logic [CHAN_W-1:0] color_out[NUM_COLORS];
		alpha_in = p[PIX_W-1 -: CHAN_W];
		for (int k = 0; k < NUM_COLORS; k++) begin
			if (alpha_in == 0)
				straight[k] = 0;
			else
				straight[k] = (longint'(p[(NUM_COLORS-1-k)*CHAN_W +: CHAN_W]) * 255
					* (longint'(1) << CHAN_FRAC_BITS)) / alpha_in;
		end
		straight[NUM_COLORS] = alpha_in * (longint'(1) << CHAN_FRAC_BITS);
		for (int r = 0; r < NUM_ROWS; r++) begin
			sum = 0;
			for (int k = 0; k < NUM_ROWS; k++) begin
				gain = $signed(gains_now[r][k*GW +: GW]);
				sum += gain * straight[k];
			end
			offs = $signed(offsets_now[r]);
			sum += offs * (longint'(1) << (SUM_FRAC - OFFSET_FRAC_BITS));
			if (sum < 0)
				clamped[r] = 0;
			else if ((sum >>> SUM_FRAC) > 255)
				clamped[r] = 255;
			else
				clamped[r] = int'(sum >>> SUM_FRAC);
		end
		new_alpha = clamped[NUM_COLORS];
		for (int c = 0; c < NUM_COLORS; c++)
			color_out[c] = CHAN_W'(clamped[c] * new_alpha / 255);
		return {CHAN_W'(new_alpha), color_out[0], color_out[1], color_out[2]};
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	// Write one register; leave valid high so a following write keeps streaming
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_BUS_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
		case (idx)
			REG_RED_GAINS:    gains_now[0]   = data;
			REG_GREEN_GAINS:  gains_now[1]   = data;
			REG_BLUE_GAINS:   gains_now[2]   = data;
			REG_ALPHA_GAINS:  gains_now[3]   = data;
			REG_RED_OFFSET:   offsets_now[0] = data[OFFSET_WIDTH-1:0];
			REG_GREEN_OFFSET: offsets_now[1] = data[OFFSET_WIDTH-1:0];
			REG_BLUE_OFFSET:  offsets_now[2] = data[OFFSET_WIDTH-1:0];
			REG_ALPHA_OFFSET: offsets_now[3] = data[OFFSET_WIDTH-1:0];
			default: ;
		endcase
	endtask

	// Load all eight registers; offsets carry random junk above bit 15
	task automatic load_matrix(gain_set_t g, offset_set_t o);
		cfg_write(REG_RED_GAINS, g[0]);
		cfg_write(REG_GREEN_GAINS, g[1]);
		cfg_write(REG_BLUE_GAINS, g[2]);
		cfg_write(REG_ALPHA_GAINS, g[3]);
		cfg_write(REG_RED_OFFSET, {$urandom, o[0]});
		cfg_write(REG_GREEN_OFFSET, {$urandom, o[1]});
		cfg_write(REG_BLUE_OFFSET, {$urandom, o[2]});
		cfg_write(REG_ALPHA_OFFSET, {$urandom, o[3]});
		cfg_valid <= 1'b0;
	endtask

	// Present one item and hold it until accepted; start stays high afterwards
	task automatic send_pixel(logic [PIX_W-1:0] p);
		start    <= 1'b1;
		pixel_in <= p;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(filter_pixel(p));
		pixels_sent++;
	endtask

	// Drop start for idle cycles, each taken with the given chance in a hundred
	task automatic pace(int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop sending and wait for every pending result
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() > 0);
	endtask

	function automatic logic [GW-1:0] rand_gain(bit on_diag);
		int pick;
		pick = $urandom_range(3);
		if (pick == 0)
			return GW'($urandom);
		if (on_diag)
			return GW'(int'(GAIN_ONE) + int'($urandom_range(192)) - 96);
		return GW'(int'($urandom_range(128)) - 64);
	endfunction

	function automatic logic [OFFSET_WIDTH-1:0] rand_offset();
		case ($urandom_range(3))
			0:       return '0;
			1:       return OFFSET_WIDTH'($urandom);
			default: return OFFSET_WIDTH'(int'($urandom_range(1024)) - 512);
		endcase
	endfunction

	// Mostly well-formed premultiplied pixels, plus zero alpha, color above alpha, noise
	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [CHAN_W-1:0] a;
		int kind;
		kind = $urandom_range(9);
		if (kind == 0)
			return $urandom;
		if (kind == 1)
			return {CHAN_W'(0), 24'($urandom)};
		if (kind == 2)
			return {CHAN_W'($urandom_range(1, 64)), 24'($urandom)};
		a = (kind == 3) ? 8'hFF : CHAN_W'($urandom_range(1, 255));
		return {a, CHAN_W'($urandom_range(a)), CHAN_W'($urandom_range(a)),
			CHAN_W'($urandom_range(a))};
	endfunction

	// Identity matrix from reset: extremes, zero alpha, color above alpha, bit patterns
	task automatic test_reset_identity();
		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h00FF_FFFF);
		send_pixel(32'h01FF_FFFF);
		send_pixel(32'h80FF_0080);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h0101_0101);
		send_pixel(32'hAAAA_AAAA);
		send_pixel(32'h5555_5555);
		send_pixel(32'h7F7F_7F7F);
		send_pixel(32'hFF80_4020);
		drain();
	endtask

	// Offsets at both ends: clamp high and low, opaque result from zero alpha
	task automatic test_offset_extremes();
		gain_set_t   g;
		offset_set_t o;
		for (int r = 0; r < NUM_ROWS; r++)
			g[r] = identity_row(r);
		o[0] = OFFSET_MAX;
		o[1] = OFFSET_MIN;
		o[2] = OFFSET_WIDTH'(16'h0640);
		o[3] = OFFSET_MAX;
		load_matrix(g, o);
		send_pixel(32'h0000_0000);
		send_pixel(32'h8040_2010);
		send_pixel(32'hFFFF_FFFF);
		drain();
		o[3] = OFFSET_MIN;
		load_matrix(g, o);
		send_pixel(32'hFF12_3456);
		drain();
	endtask

	// Every gain at its largest positive, then its most negative value
	task automatic test_gain_extremes();
		gain_set_t   g;
		offset_set_t o;
		for (int r = 0; r < NUM_ROWS; r++) begin
			g[r] = {NUM_ROWS{GAIN_MAX}};
			o[r] = '0;
		end
		load_matrix(g, o);
		send_pixel(32'h0101_0101);
		send_pixel(32'hFF01_0101);
		send_pixel(32'h40FF_00FF);
		drain();
		for (int r = 0; r < NUM_ROWS; r++) begin
			g[r] = {NUM_ROWS{GAIN_MIN}};
			o[r] = OFFSET_MAX;
		end
		load_matrix(g, o);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0100_0000);
		send_pixel(32'h0000_0000);
		drain();
	endtask

	// Writes past the last register must leave the matrix untouched
	task automatic test_stray_index();
		cfg_write(CFG_IDX_W'(NUM_REGS), '1);
		cfg_write(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '1);
		cfg_valid <= 1'b0;
		send_pixel(32'h8040_2010);
		send_pixel(32'h00FF_FFFF);
		drain();
	endtask

	// Random matrix, then a stream of random items with the given sender idling
	task automatic test_random_stream(int count, int idle_pct);
		gain_set_t   g;
		offset_set_t o;
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int k = 0; k < NUM_ROWS; k++)
				g[r][k*GW +: GW] = rand_gain(k == r);
			o[r] = rand_offset();
		end
		load_matrix(g, o);
		repeat (count) begin
			send_pixel(rand_pixel());
			pace(idle_pct);
		end
		drain();
	endtask

	// Compare each strobed result with the oldest pending prediction
	always @(posedge clk) begin
		logic [PIX_W-1:0] want;
		if (arst_n && done) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result %08h", pixel_out));
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				if (pixel_out !== want)
					report_mismatch($sformatf("pixel_out expected %08h got %08h",
						want, pixel_out));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int idle_pct;
		for (int r = 0; r < NUM_ROWS; r++) begin
			gains_now[r]   = identity_row(r);
			offsets_now[r] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_identity();
		test_offset_extremes();
		test_gain_extremes();
		test_stray_index();
		for (int phase = 0; phase < 6; phase++) begin
			idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 66 : 29;
			test_random_stream(120, idle_pct);
		end

		// Let any stray result surface
		repeat (LATENCY + 4) @(posedge clk);
		if (expected_pixels.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

		$display("Sent %0d pixels, checked %0d results, %0d register writes.",
			pixels_sent, results_checked, cfg_writes);
		$display("Covered zero alpha, color above alpha, clamp limits and sender gaps.");
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> color_matrix_pixel_filter.f
src/cmpf_pkg.sv
src/cmpf_unpremul.sv
src/cmpf_matrix.sv
src/cmpf_premul.sv
src/color_matrix_pixel_filter.sv
tb/testbench.sv
